### src/pcc_pkg.sv
// types and constants for the clamped pid controller
// no dependencies; imported by pid_controller_clamped and its testbench
`default_nettype none

package pcc_pkg;

  // input item: function code and measurement, signed q16.16
  typedef struct packed {
    logic              func;
    logic signed [31:0] measured_value;
  } pcc_in_t;

  // result item: clamped drive and clamp status
  typedef struct packed {
    logic signed [31:0] drive_value;
    logic        [1:0]  clamp_state;
  } pcc_out_t;

  // function codes
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  // clamp status codes
  localparam logic [1:0] CLAMP_NONE = 2'd0;
  localparam logic [1:0] CLAMP_MAX  = 2'd1;
  localparam logic [1:0] CLAMP_MIN  = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_SETPOINT  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_P    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_I    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_D    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_TIME_STEP = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_OUT_MIN   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_OUT_MAX   = 3'd6;

endpackage

`default_nettype wire

### src/pid_controller_clamped.sv
// clamped pid controller, signed q16.16, one shared 32x32 multiplier and
// a bit-serial divider under a small sequencer; depends on pcc_pkg
`default_nettype none

// Clamped PID controller. A sample item (func = 0) forms the error
// setpoint - measured_value, adds error * time_step to the 48-bit saturating
// integral, takes the derivative as the change in error divided by time_step
// (zero when time_step is zero), and returns gain_p*error + gain_i*integral +
// gain_d*derivative clamped first against out_max, then against out_min, with
// the clamp status. A clear item (func = 1) zeroes the integral and the
// previous error as it is accepted and gives no result. Each product is the
// exact product shifted right by 16 (toward minus infinity) and saturated to
// 48 bits. A sample item passes through the setup states ST_DIFF and ST_DINIT,
// the restoring divider (one quotient bit per cycle, skipped when time_step is
// zero), four multiplications in turn on the single 32x32 multiplier and the
// clamp step, which offers the result. The input is stalled while an item is
// in progress; a result waiting in the output register does not hold off the
// next input item, but that item waits in its clamp step while the register
// is still full and stalled. Configuration registers are written through
// cfg_we_i / cfg_addr_i / cfg_wdata_i; the user must do so only while the
// block is idle, which the block itself does not enforce; index 7 is ignored.

module pid_controller_clamped (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_addr_i,
  input  wire logic [31:0]      cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire pcc_pkg::pcc_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output pcc_pkg::pcc_out_t     out_data_o
);

  import pcc_pkg::*;

  // quotient bits: |diff| is 33 bits, shifted up by 16
  localparam int unsigned DIV_STEPS = 49;

  // multiplication slots, run in this order
  localparam logic [1:0] OP_INT = 2'd0;  // time_step * error, into integral
  localparam logic [1:0] OP_P   = 2'd1;  // gain_p * error
  localparam logic [1:0] OP_I   = 2'd2;  // gain_i * integral
  localparam logic [1:0] OP_D   = 2'd3;  // gain_d * derivative

  localparam logic signed [47:0] SAT_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] SAT_MIN = {1'b1, {47{1'b0}}};

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_DIFF  = 11'b00000000010,
    ST_DINIT = 11'b00000000100,
    ST_DIV   = 11'b00000001000,
    ST_MSEL  = 11'b00000010000,
    ST_MLO   = 11'b00000100000,
    ST_MHI   = 11'b00001000000,
    ST_MADD  = 11'b00010000000,
    ST_MRND  = 11'b00100000000,
    ST_MUSE  = 11'b01000000000,
    ST_CLAMP = 11'b10000000000
  } state_e;

  // control and state registers
  state_e state_q, state_d;
  logic signed [31:0] setpoint_q, setpoint_d;
  logic signed [31:0] gain_p_q, gain_p_d;
  logic signed [31:0] gain_i_q, gain_i_d;
  logic signed [31:0] gain_d_q, gain_d_d;
  logic        [30:0] time_step_q, time_step_d;
  logic signed [31:0] out_min_q, out_min_d;
  logic signed [31:0] out_max_q, out_max_d;
  logic signed [47:0] integ_q, integ_d;
  logic signed [32:0] prev_q, prev_d;
  logic               out_valid_q, out_valid_d;
  logic        [5:0]  cnt_q, cnt_d;
  logic        [1:0]  op_q, op_d;

  // working registers
  logic signed [32:0] err_q, err_d;
  logic signed [33:0] diff_q, diff_d;
  logic        [30:0] rem_q, rem_d;
  logic        [48:0] dq_q, dq_d;     // dividend in, quotient out
  logic        [31:0] mul_a_q, mul_a_d;
  logic        [48:0] mul_b_q, mul_b_d;
  logic               mul_neg_q, mul_neg_d;
  logic        [63:0] mul_q, mul_d;
  logic        [81:0] acc_q, acc_d;
  logic signed [47:0] prod_q, prod_d;
  logic signed [49:0] sum_q, sum_d;
  pcc_out_t           out_q, out_d;

  // datapath helpers
  logic        [31:0] b_chunk;
  logic        [63:0] mul_p;
  logic        [32:0] err_mag;
  logic        [47:0] integ_mag;
  logic signed [31:0] gain_sel;
  logic        [31:0] gain_mag;
  logic        [31:0] trial;
  logic               trial_ge;
  logic        [32:0] diff_mag;
  logic        [65:0] q_shift;
  logic signed [48:0] integ_sum;
  logic signed [49:0] max_ext;
  logic signed [49:0] min_ext;
  logic               in_accept;

  // shared multiplier, low 32-bit or high 17-bit slice of the magnitude operand
  assign b_chunk = (state_q == ST_MLO) ? mul_b_q[31:0] : {15'd0, mul_b_q[48:32]};
  assign mul_p   = mul_a_q * b_chunk;

  assign err_mag   = err_q[32] ? 33'(-err_q) : 33'(err_q);
  assign integ_mag = integ_q[47] ? 48'(-integ_q) : 48'(integ_q);
  assign diff_mag  = diff_q[33] ? 33'(-diff_q) : diff_q[32:0];

  always_comb begin
    case (op_q)
      OP_P:    gain_sel = gain_p_q;
      OP_I:    gain_sel = gain_i_q;
      default: gain_sel = gain_d_q;
    endcase
  end
  assign gain_mag = gain_sel[31] ? 32'(-gain_sel) : 32'(gain_sel);

  // restoring divider step
  assign trial    = {rem_q, dq_q[48]};
  assign trial_ge = trial >= {1'b0, time_step_q};

  // product scaled back to q16.16 (rounding term already added for negatives)
  assign q_shift = acc_q[81:16];

  assign integ_sum = $signed({integ_q[47], integ_q}) + $signed({prod_q[47], prod_q});

  assign max_ext = $signed({{18{out_max_q[31]}}, out_max_q});
  assign min_ext = $signed({{18{out_min_q[31]}}, out_min_q});

  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    setpoint_d  = setpoint_q;
    gain_p_d    = gain_p_q;
    gain_i_d    = gain_i_q;
    gain_d_d    = gain_d_q;
    time_step_d = time_step_q;
    out_min_d   = out_min_q;
    out_max_d   = out_max_q;
    integ_d     = integ_q;
    prev_d      = prev_q;
    cnt_d       = cnt_q;
    op_d        = op_q;
    err_d       = err_q;
    diff_d      = diff_q;
    rem_d       = rem_q;
    dq_d        = dq_q;
    mul_a_d     = mul_a_q;
    mul_b_d     = mul_b_q;
    mul_neg_d   = mul_neg_q;
    mul_d       = mul_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    sum_d       = sum_q;
    out_d       = out_q;

    // result register empties when taken
    out_valid_d = out_valid_q && out_stall_i;

    // configuration writes, to be issued only while idle (not enforced here)
    if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_SETPOINT:  setpoint_d  = $signed(cfg_wdata_i);
        REG_GAIN_P:    gain_p_d    = $signed(cfg_wdata_i);
        REG_GAIN_I:    gain_i_d    = $signed(cfg_wdata_i);
        REG_GAIN_D:    gain_d_d    = $signed(cfg_wdata_i);
        REG_TIME_STEP: time_step_d = cfg_wdata_i[30:0];
        REG_OUT_MIN:   out_min_d   = $signed(cfg_wdata_i);
        REG_OUT_MAX:   out_max_d   = $signed(cfg_wdata_i);
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_data_i.func == FUNC_CLEAR) begin
            integ_d = '0;
            prev_d  = '0;
          end else begin
            err_d   = $signed({setpoint_q[31], setpoint_q})
                    - $signed({in_data_i.measured_value[31], in_data_i.measured_value});
            sum_d   = '0;
            state_d = ST_DIFF;
          end
        end
      end

      ST_DIFF: begin
        diff_d  = $signed({err_q[32], err_q}) - $signed({prev_q[32], prev_q});
        state_d = ST_DINIT;
      end

      ST_DINIT: begin
        rem_d = '0;
        cnt_d = '0;
        op_d  = OP_INT;
        if (time_step_q == '0) begin
          // zero time step: derivative taken as zero
          dq_d    = '0;
          state_d = ST_MSEL;
        end else begin
          dq_d    = {diff_mag, 16'd0};
          state_d = ST_DIV;
        end
      end

      ST_DIV: begin
        rem_d = trial_ge ? 31'(trial - {1'b0, time_step_q}) : trial[30:0];
        dq_d  = {dq_q[47:0], trial_ge};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(DIV_STEPS - 1)) begin
          state_d = ST_MSEL;
        end
      end

      ST_MSEL: begin
        case (op_q)
          OP_INT: begin
            mul_a_d   = {1'b0, time_step_q};
            mul_b_d   = {16'd0, err_mag};
            mul_neg_d = err_q[32];
          end
          OP_P: begin
            mul_a_d   = gain_mag;
            mul_b_d   = {16'd0, err_mag};
            mul_neg_d = gain_p_q[31] ^ err_q[32];
          end
          OP_I: begin
            mul_a_d   = gain_mag;
            mul_b_d   = {1'b0, integ_mag};
            mul_neg_d = gain_i_q[31] ^ integ_q[47];
          end
          default: begin
            mul_a_d   = gain_mag;
            mul_b_d   = dq_q;
            mul_neg_d = gain_d_q[31] ^ diff_q[33];
          end
        endcase
        state_d = ST_MLO;
      end

      ST_MLO: begin
        mul_d   = mul_p;
        state_d = ST_MHI;
      end

      ST_MHI: begin
        acc_d   = 82'(mul_q);
        mul_d   = mul_p;
        state_d = ST_MADD;
      end

      ST_MADD: begin
        // high partial product fits in 50 bits; floor rounding term for negatives
        acc_d   = acc_q + {mul_q[49:0], 32'd0} + (mul_neg_q ? 82'h0FFFF : 82'd0);
        state_d = ST_MRND;
      end

      ST_MRND: begin
        if (mul_neg_q) begin
          if ((|q_shift[65:48]) || (q_shift[47] && (|q_shift[46:0]))) begin
            prod_d = SAT_MIN;
          end else begin
            prod_d = 48'(-q_shift[47:0]);
          end
        end else begin
          if (|q_shift[65:47]) begin
            prod_d = SAT_MAX;
          end else begin
            prod_d = $signed({1'b0, q_shift[46:0]});
          end
        end
        state_d = ST_MUSE;
      end

      ST_MUSE: begin
        if (op_q == OP_INT) begin
          if (integ_sum[48] != integ_sum[47]) begin
            integ_d = integ_sum[48] ? SAT_MIN : SAT_MAX;
          end else begin
            integ_d = integ_sum[47:0];
          end
        end else begin
          sum_d = sum_q + $signed({{2{prod_q[47]}}, prod_q});
        end
        if (op_q == OP_D) begin
          state_d = ST_CLAMP;
        end else begin
          op_d    = op_q + 2'd1;
          state_d = ST_MSEL;
        end
      end

      ST_CLAMP: begin
        // wait for the output register to free up
        if (!(out_valid_q && out_stall_i)) begin
          if (sum_q > max_ext) begin
            out_d.drive_value = out_max_q;
            out_d.clamp_state = CLAMP_MAX;
          end else if (sum_q < min_ext) begin
            out_d.drive_value = out_min_q;
            out_d.clamp_state = CLAMP_MIN;
          end else begin
            out_d.drive_value = sum_q[31:0];
            out_d.clamp_state = CLAMP_NONE;
          end
          out_valid_d = 1'b1;
          prev_d      = err_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      setpoint_q  <= '0;
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      time_step_q <= 31'd65536;
      out_min_q   <= SAT_MIN[47:16];
      out_max_q   <= SAT_MAX[47:16];
      integ_q     <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      op_q        <= OP_INT;
    end else begin
      state_q     <= state_d;
      setpoint_q  <= setpoint_d;
      gain_p_q    <= gain_p_d;
      gain_i_q    <= gain_i_d;
      gain_d_q    <= gain_d_d;
      time_step_q <= time_step_d;
      out_min_q   <= out_min_d;
      out_max_q   <= out_max_d;
      integ_q     <= integ_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      op_q        <= op_d;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    err_q     <= err_d;
    diff_q    <= diff_d;
    rem_q     <= rem_d;
    dq_q      <= dq_d;
    mul_a_q   <= mul_a_d;
    mul_b_q   <= mul_b_d;
    mul_neg_q <= mul_neg_d;
    mul_q     <= mul_d;
    acc_q     <= acc_d;
    prod_q    <= prod_d;
    sum_q     <= sum_d;
    out_q     <= out_d;
  end

endmodule

`default_nettype wire

### dv/pid_controller_clamped_tb.sv
// self-checking testbench for pid_controller_clamped: directed table then random phases,
// every result compared with its table value or with a cycle-free pid predictor written here
// depends on pcc_pkg and pid_controller_clamped
`timescale 1ns / 1ps

module pid_controller_clamped_tb;
  import pcc_pkg::*;

  // run shape
  localparam int unsigned N_PHASES      = 18;    // random phases, one setting each
  localparam int unsigned PHASE_ITEMS   = 100;   // items per random phase
  localparam int unsigned SETTLE_CYCLES = 100;   // wait after the last result, so a clear can finish
  localparam int unsigned HOLD_AT       = 450;   // items sent before the long receiver hold
  localparam int unsigned HOLD_LEN      = 300;   // cycles of that hold
  localparam int unsigned WATCHDOG      = 3000;  // cycles without any item moving
  localparam int unsigned MAX_PRINTS    = 20;

  // index past the last register, the block ignores it
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

  localparam logic signed [127:0] SAT_HI = 128'sh7FFF_FFFF_FFFF;
  localparam logic signed [127:0] SAT_LO = ~SAT_HI;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // block inputs, all known from time zero
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i  = '0;
  logic [31:0]           cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  pcc_in_t               in_data_i   = '0;
  logic                  out_stall_i = 1'b0;

  logic                  in_stall_o;
  logic                  out_valid_o;
  pcc_out_t              out_data_o;

  pid_controller_clamped dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // predictor copy of the registers and loop state
  logic signed [31:0] pr_setpoint;
  logic signed [31:0] pr_gain_p;
  logic signed [31:0] pr_gain_i;
  logic signed [31:0] pr_gain_d;
  logic        [30:0] pr_time_step;
  logic signed [31:0] pr_out_min;
  logic signed [31:0] pr_out_max;
  logic signed [47:0] pr_integral;
  logic signed [32:0] pr_prev_error;

  pcc_out_t    drive_q[$];      // expected results, oldest first
  int unsigned n_mismatch = 0;
  int unsigned n_sent     = 0;
  bit          calm       = 1'b0; // no idling on either side while set

  // one row of the directed table: either a register write or an item
  typedef struct {
    bit                    is_cfg;
    logic [CFG_ADDR_W-1:0] addr;
    logic [31:0]           wdata;
    pcc_in_t               item;
    bit                    typed;
    pcc_out_t              want;
  } stim_row_t;

  stim_row_t dir_rows[$];

  function automatic void add_cfg(input logic [CFG_ADDR_W-1:0] a, input logic [31:0] d);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.addr   = a;
    r.wdata  = d;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_item(input logic f, input logic [31:0] m);
    stim_row_t r;
    r = '{default: '0};
    r.item.func           = f;
    r.item.measured_value = m;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_sample_chk(input logic [31:0] m, input logic [31:0] d,
                                         input logic [1:0] cs);
    stim_row_t r;
    r = '{default: '0};
    r.item.func           = FUNC_SAMPLE;
    r.item.measured_value = m;
    r.typed               = 1'b1;
    r.want.drive_value    = d;
    r.want.clamp_state    = cs;
    dir_rows.push_back(r);
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [127:0] v);
    if (v > SAT_HI) return SAT_HI[47:0];
    if (v < SAT_LO) return SAT_LO[47:0];
    return v[47:0];
  endfunction

  // q16.16 product, floor shift by 16, saturated to 48 bits
  function automatic logic signed [47:0] mul_q16(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [127:0] wa, wb;
    wa = a;
    wb = b;
    return sat48((wa * wb) >>> 16);
  endfunction

  // advances the loop state for one accepted item, returns 1 if a result follows
  function automatic bit pid_predict(input pcc_in_t it, output pcc_out_t res);
    logic signed [63:0] err, diff, deriv, ts64, sum, term_p, term_i, term_d;
    logic signed [31:0] meas;
    res = '0;
    if (it.func == FUNC_CLEAR) begin
      pr_integral   = '0;
      pr_prev_error = '0;
      return 1'b0;
    end
    meas = it.measured_value;
    ts64 = {33'd0, pr_time_step};
    err  = pr_setpoint;
    err  = err - meas;
    // integral first, the new value feeds the i term
    pr_integral = sat48(pr_integral + mul_q16(err, ts64));
    diff = err - pr_prev_error;
    // zero time step: derivative taken as zero
    if (pr_time_step == '0) deriv = '0;
    else deriv = (diff <<< 16) / ts64;
    term_p = mul_q16(pr_gain_p, err);
    term_i = mul_q16(pr_gain_i, pr_integral);
    term_d = mul_q16(pr_gain_d, deriv);
    sum = term_p + term_i + term_d;
    // max is tested before min, so min above max still resolves
    if (sum > pr_out_max) begin
      res.drive_value = pr_out_max;
      res.clamp_state = CLAMP_MAX;
    end else if (sum < pr_out_min) begin
      res.drive_value = pr_out_min;
      res.clamp_state = CLAMP_MIN;
    end else begin
      res.drive_value = sum[31:0];
      res.clamp_state = CLAMP_NONE;
    end
    pr_prev_error = err[32:0];
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    n_mismatch++;
    if (n_mismatch <= MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // register write, one cycle of enable, predictor follows at the same edge
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] a, input logic [31:0] d);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= a;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (a)
      REG_SETPOINT:  pr_setpoint  = d;
      REG_GAIN_P:    pr_gain_p    = d;
      REG_GAIN_I:    pr_gain_i    = d;
      REG_GAIN_D:    pr_gain_d    = d;
      REG_TIME_STEP: pr_time_step = d[30:0];
      REG_OUT_MIN:   pr_out_min   = d;
      REG_OUT_MAX:   pr_out_max   = d;
      default: ;
    endcase
  endtask

  // offer one item; valid stays high after acceptance so back-to-back items
  // never lower and raise it in one step
  task automatic send_item(input pcc_in_t it, input bit typed, input pcc_out_t want);
    pcc_out_t res;
    while (!calm && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n_sent++;
    if (pid_predict(it, res)) drive_q.push_back(typed ? want : res);
  endtask

  // sender goes quiet until every result is in, then lets a clear finish
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // receiver: random stall, one long hold once HOLD_AT items have been sent
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (!hold_done && n_sent >= HOLD_AT) begin
      // sender keeps offering, so the block fills and stalls its input
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_LEN;
      hold_done   <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 18);
    end
  end

  // result checker
  pcc_out_t got_want;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (drive_q.size() == 0) begin
        report_mismatch($sformatf("result 0x%08h/%0d with no item pending",
                                  out_data_o.drive_value, out_data_o.clamp_state));
      end else begin
        got_want = drive_q.pop_front();
        if (out_data_o.drive_value !== got_want.drive_value)
          report_mismatch($sformatf("drive_value 0x%08h, expected 0x%08h",
                                    out_data_o.drive_value, got_want.drive_value));
        if (out_data_o.clamp_state !== got_want.clamp_state)
          report_mismatch($sformatf("clamp_state %0d, expected %0d",
                                    out_data_o.clamp_state, got_want.clamp_state));
      end
    end
  end

  // watchdog on cycles where no item moves on either side
  int unsigned still_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) still_cycles <= 0;
    else still_cycles <= still_cycles + 1;
    if (still_cycles >= WATCHDOG) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG);
      $display("[pid_controller_clamped] ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin
    bit          dirty;
    pcc_in_t     it;
    int          off;
    int unsigned sel;
    logic [31:0] lo, hi, w;

    // reset values of the predictor
    pr_setpoint   = '0;
    pr_gain_p     = '0;
    pr_gain_i     = '0;
    pr_gain_d     = '0;
    pr_time_step  = 31'd65536;
    pr_out_min    = 32'sh8000_0000;
    pr_out_max    = 32'sh7FFF_FFFF;
    pr_integral   = '0;
    pr_prev_error = '0;
    dirty         = 1'b0;

    // directed table
    // gains all zero after reset: output is zero whatever the measurement
    add_sample_chk(32'h0000_0000, 32'h0000_0000, CLAMP_NONE);
    add_sample_chk(32'h8000_0000, 32'h0000_0000, CLAMP_NONE);
    add_sample_chk(32'h7FFF_FFFF, 32'h0000_0000, CLAMP_NONE);
    // unity p gain, reset limits: most negative measurement hits max
    add_cfg(REG_GAIN_P, 32'h0001_0000);
    add_sample_chk(32'h8000_0000, 32'h7FFF_FFFF, CLAMP_MAX);
    add_sample_chk(32'h7FFF_FFFF, 32'h8000_0001, CLAMP_NONE);
    // min above max
    add_cfg(REG_OUT_MAX, 32'h0000_0000);
    add_cfg(REG_OUT_MIN, 32'h0001_0000);
    add_sample_chk(32'hFFFF_0000, 32'h0000_0000, CLAMP_MAX);
    add_sample_chk(32'h0001_0000, 32'h0001_0000, CLAMP_MIN);
    add_sample_chk(32'h0000_0000, 32'h0001_0000, CLAMP_MIN);
    add_cfg(REG_OUT_MIN, 32'h8000_0000);
    add_cfg(REG_OUT_MAX, 32'h7FFF_FFFF);
    add_cfg(REG_UNUSED, 32'hDEAD_BEEF);
    // largest error, extreme gains, longest time step: integral saturates
    add_cfg(REG_SETPOINT, 32'h7FFF_FFFF);
    add_item(FUNC_SAMPLE, 32'h8000_0000);
    add_cfg(REG_GAIN_I, 32'h7FFF_FFFF);
    add_cfg(REG_GAIN_D, 32'h8000_0000);
    add_cfg(REG_TIME_STEP, 32'h7FFF_FFFF);
    add_item(FUNC_SAMPLE, 32'h8000_0000);
    add_item(FUNC_SAMPLE, 32'h8000_0000);
    add_item(FUNC_SAMPLE, 32'h7FFF_FFFF);
    // clear, measurement ignored
    add_item(FUNC_CLEAR, 32'h1234_5678);
    add_item(FUNC_SAMPLE, 32'h8000_0000);
    // smallest time step: huge derivative, most negative error
    add_cfg(REG_TIME_STEP, 32'h0000_0001);
    add_cfg(REG_SETPOINT, 32'h8000_0000);
    add_cfg(REG_GAIN_P, 32'h8000_0000);
    add_item(FUNC_SAMPLE, 32'h7FFF_FFFF);
    add_item(FUNC_SAMPLE, 32'h8000_0000);
    add_item(FUNC_SAMPLE, 32'h7FFF_FFFF);
    // zero time step: integral frozen, derivative zero
    add_cfg(REG_TIME_STEP, 32'h0000_0000);
    add_item(FUNC_SAMPLE, 32'h0000_1234);
    add_item(FUNC_SAMPLE, 32'hFFFF_0000);
    add_item(FUNC_CLEAR, 32'hFFFF_FFFF);
    add_item(FUNC_SAMPLE, 32'h0000_0000);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].is_cfg) begin
        if (dirty) wait_idle();
        dirty = 1'b0;
        write_reg(dir_rows[r].addr, dir_rows[r].wdata);
      end else begin
        send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);
        dirty = 1'b1;
      end
    end

    // random phases, each with its own setting
    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      calm <= (ph == 13 || ph == 14);

      // setpoint: moderate half the time, else an extreme or anywhere
      sel = $urandom_range(3);
      if (sel == 0) w = $urandom;
      else if (sel == 1) w = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      else w = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      write_reg(REG_SETPOINT, w);

      // gains: zero, small signed, extremes or full width
      for (int g = 0; g < 3; g++) begin
        sel = $urandom_range(9);
        if (sel == 0) w = '0;
        else if (sel < 6) w = $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
        else if (sel < 8) w = $urandom;
        else w = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        write_reg(g == 0 ? REG_GAIN_P : (g == 1 ? REG_GAIN_I : REG_GAIN_D), w);
      end

      // time step: unity, extremes, small or full width (bit 31 is dropped)
      sel = $urandom_range(5);
      case (sel)
        0: w = 32'h0001_0000;
        1: w = 32'h0000_0001;
        2: w = 32'h7FFF_FFFF;
        3: w = $urandom;
        default: w = $urandom_range(1, 32'h0004_0000);
      endcase
      write_reg(REG_TIME_STEP, w);

      // limits: reset span, ordered window, or raw (min may sit above max)
      sel = $urandom_range(3);
      if (sel == 0) begin
        lo = 32'h8000_0000;
        hi = 32'h7FFF_FFFF;
      end else if (sel == 3) begin
        lo = $urandom;
        hi = $urandom;
      end else begin
        lo = -$urandom_range(0, 32'h0010_0000);
        hi = $urandom_range(0, 32'h0010_0000);
      end
      write_reg(REG_OUT_MIN, lo);
      write_reg(REG_OUT_MAX, hi);
      if ($urandom_range(7) == 0) write_reg(REG_UNUSED, $urandom);

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // one pause mid-phase until every result has come back
        if (ph == 9 && i == PHASE_ITEMS / 2) wait_idle();
        sel = $urandom_range(99);
        it.func = (sel < 5) ? FUNC_CLEAR : FUNC_SAMPLE;
        sel = $urandom_range(99);
        if (sel < 60) begin
          // tracking near the setpoint, the usual loop behavior
          off = $urandom_range(0, 32'h0002_0000);
          if ($urandom_range(1)) off = -off;
          it.measured_value = pr_setpoint + off;
        end else if (sel < 80) begin
          it.measured_value = $urandom;
        end else if (sel < 90) begin
          case ($urandom_range(3))
            0: it.measured_value = 32'h8000_0000;
            1: it.measured_value = 32'h7FFF_FFFF;
            2: it.measured_value = 32'h0000_0000;
            default: it.measured_value = 32'hFFFF_FFFF;
          endcase
        end else begin
          off = $urandom_range(0, 32'h0100_0000);
          if ($urandom_range(1)) off = -off;
          it.measured_value = pr_setpoint + off;
        end
        send_item(it, 1'b0, '0);
      end
    end

    calm <= 1'b0;
    wait_idle();
    if (drive_q.size() != 0) report_mismatch("results still expected at end");
    if (n_mismatch == 0) begin
      $display("[pid_controller_clamped] OK");
    end else begin
      $display("[pid_controller_clamped] ERROR");
    end
    $finish;
  end

endmodule
